>>> design/quad_to_double_double_convert_macros.svh
// Assertion helpers shared by the converter.
`ifndef QUAD_TO_DOUBLE_DOUBLE_CONVERT_MACROS_SVH
`define QUAD_TO_DOUBLE_DOUBLE_CONVERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QDD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qdd assertion failed");

// Next-cycle implication, disabled during reset.
`define QDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qdd assertion failed");

`endif

>>> design/qdd_pkg.sv
package qdd_pkg;

  localparam int QUAD_EXP_MAX = 32767;
  localparam int QUAD_BIAS    = 16383;
  localparam int DBL_EXP_MAX  = 2047;
  localparam int DBL_BIAS     = 1023;
  localparam int LOWER_OFFSET = 53;

  // Quad exponent thresholds (biased).
  localparam logic [14:0] QEXP_ALL_ONES = 15'(QUAD_EXP_MAX);
  localparam logic [14:0] QEXP_UNF      = 15'(QUAD_BIAS - DBL_BIAS);
  localparam logic [14:0] QEXP_OVF      = 15'(QUAD_BIAS - DBL_BIAS + DBL_EXP_MAX);
  localparam logic [14:0] QEXP_LOW      = 15'(QUAD_BIAS - DBL_BIAS + LOWER_OFFSET);
  localparam logic [10:0] DEXP_ALL_ONES = 11'(DBL_EXP_MAX);

  typedef struct packed {
    logic        sign;
    logic [63:0] upper;
    logic        lower_en;
    logic [10:0] e2;
    logic [59:0] mant;
  } dec_t;

  typedef struct packed {
    logic        sign;
    logic [63:0] upper;
    logic        lower_en;
    logic [10:0] e2;
    logic [59:0] mant;
    logic [5:0]  lz;
  } lzc_t;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
  } res_t;

  // Leading zeros of a nonzero 60-bit word (59 for a lone LSB).
  function automatic logic [5:0] lead_zeros(input logic [59:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 60; i++) begin
      if (v[i]) begin
        n = 6'(59 - i);
      end
    end
    return n;
  endfunction

endpackage

>>> design/qdd_decode.sv
module qdd_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [63:0]      quad_high,
  input  logic [63:0]      quad_low,
  output logic             dn_valid,
  input  logic             dn_ready,
  output qdd_pkg::dec_t    dn_data
);
  import qdd_pkg::*;

  logic        sign;
  logic [14:0] qexp;
  logic [51:0] frac_hi;
  logic [59:0] mant;
  dec_t        dec_next;

  assign sign    = quad_high[63];
  assign qexp    = quad_high[62:48];
  assign frac_hi = {quad_high[47:0], quad_low[63:60]};
  assign mant    = quad_low[59:0];

  always_comb begin
    dec_next          = '0;
    dec_next.sign     = sign;
    dec_next.mant     = mant;
    dec_next.e2       = 11'(qexp - QEXP_LOW);
    dec_next.upper    = {sign, 63'd0};
    dec_next.lower_en = 1'b0;
    if (qexp == QEXP_ALL_ONES) begin
      // keep NaN a NaN when only low fraction bits are set
      dec_next.upper = {sign, DEXP_ALL_ONES,
                        ((frac_hi == '0) && (mant != '0)) ? 52'd1 : frac_hi};
    end else if (qexp == '0) begin
      dec_next.upper = {sign, 63'd0};
    end else if (qexp >= QEXP_OVF) begin
      dec_next.upper = {sign, DEXP_ALL_ONES, 52'd0};
    end else if (qexp <= QEXP_UNF) begin
      dec_next.upper = {sign, 63'd0};
    end else begin
      dec_next.upper    = {sign, 11'(qexp - QEXP_UNF), frac_hi};
      dec_next.lower_en = (mant != '0) && (qexp > QEXP_LOW);
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= dec_next;
    end
  end

endmodule

>>> design/qdd_lzc.sv
module qdd_lzc (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  qdd_pkg::dec_t    up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output qdd_pkg::lzc_t    dn_data
);
  import qdd_pkg::*;

  lzc_t lzc_next;

  always_comb begin
    lzc_next.sign     = up_data.sign;
    lzc_next.upper    = up_data.upper;
    lzc_next.lower_en = up_data.lower_en;
    lzc_next.e2       = up_data.e2;
    lzc_next.mant     = up_data.mant;
    lzc_next.lz       = lead_zeros(up_data.mant);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= lzc_next;
    end
  end

endmodule

>>> design/qdd_pack.sv
module qdd_pack (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  qdd_pkg::lzc_t    up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output qdd_pkg::res_t    dn_data
);
  import qdd_pkg::*;

  logic [59:0] norm;
  logic [11:0] e_lo;
  res_t        res_next;

  assign norm = up_data.mant << up_data.lz;
  assign e_lo = {1'b0, up_data.e2} - {6'd0, up_data.lz};

  always_comb begin
    res_next.upper = up_data.upper;
    if (up_data.lower_en && !e_lo[11] && (e_lo != '0)) begin
      // hidden bit norm[59] dropped
      res_next.lower = {up_data.sign, e_lo[10:0], norm[58:7]};
    end else begin
      res_next.lower = {up_data.sign, 63'd0};
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= res_next;
    end
  end

endmodule

>>> design/quad_to_double_double_convert.sv
// Binary128 to double-double converter.
// Input channel: quad_valid/quad_ready carry one request of a quad value split
//   into quad_high (sign, exponent, top 48 fraction bits) and quad_low.
// Output channel: dd_valid/dd_ready carry upper_double and lower_double, one
//   result per request, in request order.
// Path: an accepted request passes through the decode, leading-zero count and
//   normalize/pack register stages, in that order, before dd_valid rises.
// Throughput: one request per cycle while dd_ready stays high; each stage has its
//   own valid bit and accepts when empty or when its successor takes its contents.
// Stall: with dd_ready low the pipeline fills and quad_ready drops after
//   three held requests; nothing is lost or repeated.
// Reset (rst, synchronous): clears all stage valid bits; data registers are
//   left as they are. No other state exists.
// Specials: Inf/NaN keep a nonzero NaN fraction; quad denormals, exponent
//   underflow and an empty or out-of-range low part give signed zero;
//   exponent overflow gives signed infinity.
module quad_to_double_double_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        quad_valid,
  output logic        quad_ready,
  input  logic [63:0] quad_high,
  input  logic [63:0] quad_low,
  output logic        dd_valid,
  input  logic        dd_ready,
  output logic [63:0] upper_double,
  output logic [63:0] lower_double
);
  import qdd_pkg::*;

  `include "quad_to_double_double_convert_macros.svh"

  logic  dec_valid;
  logic  dec_ready;
  dec_t  dec_data;
  logic  lzc_valid;
  logic  lzc_ready;
  lzc_t  lzc_data;
  res_t  res_data;

  // stage 1: classify exponent, build upper double
  qdd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (quad_valid),
    .up_ready  (quad_ready),
    .quad_high (quad_high),
    .quad_low  (quad_low),
    .dn_valid  (dec_valid),
    .dn_ready  (dec_ready),
    .dn_data   (dec_data)
  );

  // stage 2: leading-zero count of the 60 low fraction bits
  qdd_lzc u_lzc (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (lzc_valid),
    .dn_ready (lzc_ready),
    .dn_data  (lzc_data)
  );

  // stage 3: normalize, adjust exponent, pack lower double
  qdd_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .up_valid (lzc_valid),
    .up_ready (lzc_ready),
    .up_data  (lzc_data),
    .dn_valid (dd_valid),
    .dn_ready (dd_ready),
    .dn_data  (res_data)
  );

  assign upper_double = res_data.upper;
  assign lower_double = res_data.lower;

  // an accepted request always lands in the decode stage
  `QDD_ASSERT_NEXT(a_enter, clk, rst, quad_valid && quad_ready, dec_valid)
  // both halves share the input sign
  `QDD_ASSERT_NOW(a_sign, clk, rst, dd_valid, upper_double[63] == lower_double[63])
  // a live low part implies a finite, normal upper part
  `QDD_ASSERT_NOW(a_lower_normal, clk, rst, dd_valid && (lower_double[62:52] != '0),
    (upper_double[62:52] != '0) && (upper_double[62:52] != DEXP_ALL_ONES))
  // a zero upper exponent is always a flushed signed zero
  `QDD_ASSERT_NOW(a_flush, clk, rst, dd_valid && (upper_double[62:52] == '0),
    (upper_double[51:0] == '0) && (lower_double[62:0] == '0))

endmodule
